@@ rtl/pdll_pkg.sv @@
// shared types, constants and helpers for the pooled doubly linked list unit
package pdll_pkg;

    localparam int SLOTS   = 64;
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int LINK_W  = SLOT_W + 1;
    localparam int VALUE_W = 32;

    localparam logic [LINK_W-1:0] NIL_LINK  = LINK_W'(SLOTS);
    localparam logic [LINK_W-1:0] FULL_COUNT = LINK_W'(SLOTS);

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_DROP = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOT_USED = 2'd2;

    typedef struct packed {
        logic               operation;
        logic [VALUE_W-1:0] item_value;
        logic [SLOT_W-1:0]  slot_index;
    } in_item_t;

    typedef struct packed {
        logic [SLOT_W-1:0] result_slot;
        logic [1:0]        status;
        logic [LINK_W-1:0] entry_count;
        logic [LINK_W-1:0] head_slot;
        logic [LINK_W-1:0] tail_slot;
    } out_item_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_ADD_LINK,
        S_DROP_LINK,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic capture;
        logic add_place;
        logic add_link;
        logic drop_link;
        logic reject_full;
        logic reject_unused;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic is_drop;
        logic pool_full;
        logic slot_in_use;
        logic out_free;
    } stat_t;

    // lowest-numbered clear bit of the occupancy vector
    function automatic logic [SLOT_W-1:0] first_free(input logic [SLOTS-1:0] used);
        logic [SLOT_W-1:0] pick;
        pick = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!used[i])
            begin
                pick = SLOT_W'(i);
            end
        end
        return pick;
    endfunction

endpackage

@@ rtl/pdll_ram.sv @@
// generic single write port ram with registered read
module pdll_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                     clk,
    input  logic                                     wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ rtl/pdll_ctrl.sv @@
// sequencing state machine for the pooled list unit
module pdll_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  pdll_pkg::stat_t  stat,
    output pdll_pkg::cmd_t   cmd
);

    pdll_pkg::state_t state_reg;
    pdll_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pdll_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pdll_pkg::S_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = pdll_pkg::S_DECODE;
                end
            end
            pdll_pkg::S_DECODE:
            begin
                if (stat.is_drop)
                begin
                    state_next = stat.slot_in_use ? pdll_pkg::S_DROP_LINK : pdll_pkg::S_RESULT;
                end
                else
                begin
                    state_next = stat.pool_full ? pdll_pkg::S_RESULT : pdll_pkg::S_ADD_LINK;
                end
            end
            pdll_pkg::S_ADD_LINK:  state_next = pdll_pkg::S_RESULT;
            pdll_pkg::S_DROP_LINK: state_next = pdll_pkg::S_RESULT;
            pdll_pkg::S_RESULT:
            begin
                if (stat.out_free)
                begin
                    state_next = pdll_pkg::S_IDLE;
                end
            end
            default: state_next = pdll_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        item_stall = 1'b1;
        case (state_reg)
            pdll_pkg::S_IDLE:
            begin
                item_stall  = 1'b0;
                cmd.capture = item_valid;
            end
            pdll_pkg::S_DECODE:
            begin
                if (stat.is_drop)
                begin
                    cmd.reject_unused = !stat.slot_in_use;
                end
                else
                begin
                    cmd.reject_full = stat.pool_full;
                    cmd.add_place   = !stat.pool_full;
                end
            end
            pdll_pkg::S_ADD_LINK:  cmd.add_link  = 1'b1;
            pdll_pkg::S_DROP_LINK: cmd.drop_link = 1'b1;
            pdll_pkg::S_RESULT:    cmd.load_out  = stat.out_free;
            default:               cmd = '0;
        endcase
    end

endmodule

@@ rtl/pdll_datapath.sv @@
// occupancy bits, link tables, list pointers and result register
module pdll_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pdll_pkg::in_item_t   item,
    input  pdll_pkg::cmd_t       cmd,
    output pdll_pkg::stat_t      stat,
    output logic                 result_valid,
    input  logic                 result_stall,
    output pdll_pkg::out_item_t  result
);

    localparam int SW = pdll_pkg::SLOT_W;
    localparam int LW = pdll_pkg::LINK_W;

    // captured item
    logic                        op_reg;
    logic [pdll_pkg::VALUE_W-1:0] value_reg;
    logic [SW-1:0]               idx_reg;

    // list state
    logic [pdll_pkg::SLOTS-1:0]  used_reg, used_next;
    logic [LW-1:0]               head_reg, head_next;
    logic [LW-1:0]               tail_reg, tail_next;
    logic [LW-1:0]               count_reg, count_next;

    // per-item working registers
    logic [SW-1:0]               free_reg;
    logic [SW-1:0]               res_slot_reg;
    logic [1:0]                  res_status_reg;

    logic                        out_valid_reg, out_valid_next;
    pdll_pkg::out_item_t         out_reg;

    logic [SW-1:0]               free_slot;
    logic [LW-1:0]               prev_rd, next_rd;

    logic                        next_we, prev_we;
    logic [SW-1:0]               next_wa, prev_wa;
    logic [LW-1:0]               next_wd, prev_wd;

    assign free_slot = pdll_pkg::first_free(used_reg);

    // a 6-bit slot index can never reach past the pool, so only occupancy is tested
    assign stat.is_drop     = (op_reg == pdll_pkg::OP_DROP);
    assign stat.pool_full   = (count_reg == pdll_pkg::FULL_COUNT);
    assign stat.slot_in_use = used_reg[idx_reg];
    assign stat.out_free    = !out_valid_reg || !result_stall;

    // next link table writes
    always_comb
    begin
        next_we = 1'b0;
        next_wa = free_slot;
        next_wd = pdll_pkg::NIL_LINK;
        if (cmd.add_place)
        begin
            next_we = 1'b1;
        end
        else if (cmd.add_link)
        begin
            next_we = (tail_reg != pdll_pkg::NIL_LINK);
            next_wa = tail_reg[SW-1:0];
            next_wd = {1'b0, free_reg};
        end
        else if (cmd.drop_link)
        begin
            next_we = (prev_rd != pdll_pkg::NIL_LINK);
            next_wa = prev_rd[SW-1:0];
            next_wd = next_rd;
        end
    end

    // prev link table writes
    always_comb
    begin
        prev_we = 1'b0;
        prev_wa = free_slot;
        prev_wd = tail_reg;
        if (cmd.add_place)
        begin
            prev_we = 1'b1;
        end
        else if (cmd.drop_link)
        begin
            prev_we = (next_rd != pdll_pkg::NIL_LINK);
            prev_wa = next_rd[SW-1:0];
            prev_wd = prev_rd;
        end
    end

    pdll_ram #(.WIDTH(LW), .DEPTH(pdll_pkg::SLOTS)) u_next_ram (
        .clk     (clk),
        .wr_en   (next_we),
        .wr_addr (next_wa),
        .wr_data (next_wd),
        .rd_addr (idx_reg),
        .rd_data (next_rd)
    );

    pdll_ram #(.WIDTH(LW), .DEPTH(pdll_pkg::SLOTS)) u_prev_ram (
        .clk     (clk),
        .wr_en   (prev_we),
        .wr_addr (prev_wa),
        .wr_data (prev_wd),
        .rd_addr (idx_reg),
        .rd_data (prev_rd)
    );

    // stored values are kept but never read back
    pdll_ram #(.WIDTH(pdll_pkg::VALUE_W), .DEPTH(pdll_pkg::SLOTS)) u_value_ram (
        .clk     (clk),
        .wr_en   (cmd.add_place),
        .wr_addr (free_slot),
        .wr_data (value_reg),
        .rd_addr ('0),
        .rd_data ()
    );

    always_comb
    begin
        used_next      = used_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        if (cmd.add_link)
        begin
            used_next[free_reg] = 1'b1;
            if (tail_reg == pdll_pkg::NIL_LINK)
            begin
                head_next = {1'b0, free_reg};
            end
            tail_next  = {1'b0, free_reg};
            count_next = count_reg + LW'(1);
        end
        else if (cmd.drop_link)
        begin
            used_next[idx_reg] = 1'b0;
            if (prev_rd == pdll_pkg::NIL_LINK)
            begin
                head_next = next_rd;
            end
            if (next_rd == pdll_pkg::NIL_LINK)
            begin
                tail_next = prev_rd;
            end
            count_next = count_reg - LW'(1);
        end
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            head_reg      <= pdll_pkg::NIL_LINK;
            tail_reg      <= pdll_pkg::NIL_LINK;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            used_reg      <= used_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= item.operation;
            value_reg <= item.item_value;
            idx_reg   <= item.slot_index;
        end
        if (cmd.add_place)
        begin
            free_reg <= free_slot;
        end
        if (cmd.add_link)
        begin
            res_slot_reg   <= free_reg;
            res_status_reg <= pdll_pkg::ST_OK;
        end
        if (cmd.drop_link)
        begin
            res_slot_reg   <= idx_reg;
            res_status_reg <= pdll_pkg::ST_OK;
        end
        if (cmd.reject_full)
        begin
            res_slot_reg   <= '0;
            res_status_reg <= pdll_pkg::ST_FULL;
        end
        if (cmd.reject_unused)
        begin
            res_slot_reg   <= idx_reg;
            res_status_reg <= pdll_pkg::ST_NOT_USED;
        end
        if (cmd.load_out)
        begin
            out_reg.result_slot <= res_slot_reg;
            out_reg.status      <= res_status_reg;
            out_reg.entry_count <= count_reg;
            out_reg.head_slot   <= head_reg;
            out_reg.tail_slot   <= tail_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

@@ rtl/pooled_doubly_linked_list_unit.sv @@
// top level of the pooled doubly linked list unit
//
// channel   signals                            carries per beat
// -------   --------------------------------   ----------------------------------------
// item      item_valid, item_stall, item       operation, item_value, slot_index
// result    result_valid, result_stall, result result_slot, status, entry_count, head, tail
//
// adds and drops step through accept, decode (free-slot priority encoder or
// link table read), link table update and result load; a refused add or drop
// skips the table update; one item is in flight at a time; the link tables are
// single write port rams
// reset clears the occupancy bits, head, tail and count at once; no clearing pass
// a stalled result holds in its register while the next item is accepted and
// worked on; that item then waits in its last step until the register frees
module pooled_doubly_linked_list_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  pdll_pkg::in_item_t   item,
    output logic                 result_valid,
    input  logic                 result_stall,
    output pdll_pkg::out_item_t  result
);

    // command and status between sequencer and datapath
    pdll_pkg::cmd_t  cmd;
    pdll_pkg::stat_t stat;

    // sequencer: decides add, drop or refusal and steps the table updates
    pdll_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .stat       (stat),
        .cmd        (cmd)
    );

    // datapath: occupancy, next and prev link rams, value ram, pointers, result register
    pdll_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .stat         (stat),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

@@ rtl/pdll_checker.sv @@
// port-level checks for the pooled list unit, bound to the top level
module pdll_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 item_valid,
    input logic                 item_stall,
    input logic                 result_valid,
    input logic                 result_stall,
    input pdll_pkg::out_item_t  result
);

    // a held result beat keeps its contents
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result beat changed while stalled");

    // one item at a time: the beat after an accepted item is refused
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
        else $error("item accepted while another is in flight");

    // an empty list has no head and no tail, a non-empty one has both
    a_empty_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |->
            ((result.entry_count == '0) == (result.head_slot == pdll_pkg::NIL_LINK)) &&
            ((result.entry_count == '0) == (result.tail_slot == pdll_pkg::NIL_LINK)))
        else $error("count disagrees with head or tail");

    // a refused add only happens on a full pool and names slot zero
    a_full_refusal: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status == pdll_pkg::ST_FULL |->
            result.entry_count == pdll_pkg::FULL_COUNT && result.result_slot == '0)
        else $error("full status on a pool that is not full");

    // count never passes the pool size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.entry_count <= pdll_pkg::FULL_COUNT)
        else $error("entry count beyond pool size");

endmodule

bind pooled_doubly_linked_list_unit pdll_checker u_pdll_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

@@ sim/pdll_list_checker.sv @@
// checker for the pooled doubly linked list unit: list predictor and result comparison
module pdll_list_checker
    import pdll_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    input  logic      item_stall,
    input  in_item_t  item,
    input  logic      result_valid,
    input  logic      result_stall,
    input  out_item_t result,
    output int        failures,
    output int        outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // predicted list state
    logic [SLOTS-1:0]  in_use;
    logic [LINK_W-1:0] fwd_link [SLOTS];
    logic [LINK_W-1:0] back_link [SLOTS];
    logic [LINK_W-1:0] list_head;
    logic [LINK_W-1:0] list_tail;
    logic [LINK_W-1:0] live_count;

    out_item_t expected_results [$];
    out_item_t oldest;

    function automatic out_item_t apply_list_op(input in_item_t beat);
        out_item_t         r;
        logic [LINK_W-1:0] p;
        logic [LINK_W-1:0] n;
        int                pick;
        r    = '0;
        pick = SLOTS;
        if (beat.operation == OP_ADD)
        begin
            for (int i = SLOTS - 1; i >= 0; i--)
            begin
                if (!in_use[i])
                begin
                    pick = i;
                end
            end
            if (pick == SLOTS)
            begin
                r.status = ST_FULL;
            end
            else
            begin
                in_use[pick]    = 1'b1;
                back_link[pick] = list_tail;
                fwd_link[pick]  = NIL_LINK;
                if (list_tail == NIL_LINK)
                begin
                    list_head = LINK_W'(pick);
                end
                else
                begin
                    fwd_link[list_tail] = LINK_W'(pick);
                end
                list_tail     = LINK_W'(pick);
                live_count    = live_count + 1'b1;
                r.result_slot = SLOT_W'(pick);
                r.status      = ST_OK;
            end
        end
        else
        begin
            r.result_slot = beat.slot_index;
            if (!in_use[beat.slot_index])
            begin
                r.status = ST_NOT_USED;
            end
            else
            begin
                p = back_link[beat.slot_index];
                n = fwd_link[beat.slot_index];
                // splice the neighbours together, head and tail where at an end
                if (p == NIL_LINK)
                begin
                    list_head = n;
                end
                else
                begin
                    fwd_link[p] = n;
                end
                if (n == NIL_LINK)
                begin
                    list_tail = p;
                end
                else
                begin
                    back_link[n] = p;
                end
                in_use[beat.slot_index]    = 1'b0;
                fwd_link[beat.slot_index]  = NIL_LINK;
                back_link[beat.slot_index] = NIL_LINK;
                live_count                 = live_count - 1'b1;
                r.status                   = ST_OK;
            end
        end
        r.entry_count = live_count;
        r.head_slot   = list_head;
        r.tail_slot   = list_tail;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use     = '0;
            list_head  = NIL_LINK;
            list_tail  = NIL_LINK;
            live_count = '0;
            expected_results.delete();
            failures    = 0;
            outstanding = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    failures++;
                    if (failures <= 10)
                    begin
                        $display("%0t: unexpected result beat slot %0d status %0d count %0d head %0d tail %0d",
                                 $time, result.result_slot, result.status, result.entry_count,
                                 result.head_slot, result.tail_slot);
                    end
                end
                else
                begin
                    oldest = expected_results.pop_front();
                    if (result !== oldest)
                    begin
                        failures++;
                        if (failures <= 10)
                        begin
                            $display("%0t: result mismatch, expected slot %0d status %0d count %0d head %0d tail %0d",
                                     $time, oldest.result_slot, oldest.status,
                                     oldest.entry_count, oldest.head_slot, oldest.tail_slot);
                            $display("%0t:                  actual   slot %0d status %0d count %0d head %0d tail %0d",
                                     $time, result.result_slot, result.status,
                                     result.entry_count, result.head_slot, result.tail_slot);
                        end
                    end
                end
            end
            if (item_valid && !item_stall)
            begin
                expected_results.push_back(apply_list_op(item));
            end
            outstanding = expected_results.size();
        end
    end

endmodule

@@ sim/tb_pooled_doubly_linked_list_unit.sv @@
// testbench top for the pooled doubly linked list unit: stimulus, back-pressure and verdict
module tb_pooled_doubly_linked_list_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import pdll_pkg::*;

    // mix of adds and drops within one stretch of random traffic
    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN, MIX_NOISE} traffic_t;
    // result side back-pressure modes
    typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

    localparam int TOTAL_ITEMS = 2020;

    logic      clk          = 1'b0;
    logic      rst_n        = 1'b0;
    logic      item_valid   = 1'b0;
    in_item_t  item         = '0;
    logic      item_stall;
    logic      result_valid;
    logic      result_stall = 1'b0;
    out_item_t result;

    int failures;
    int outstanding;

    // light occupancy mirror, only used to aim drops at live slots
    logic [SLOTS-1:0] occupied   = '0;
    int               burst_left = 0;
    int               items_sent = 0;
    int               stall_left = 0;
    rx_mode_t         stall_mode = RX_FREE;

    pooled_doubly_linked_list_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    pdll_list_checker list_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .failures     (failures),
        .outstanding  (outstanding)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // hard stop well beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // result side: each mode holds for a random stretch, free stretches included
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else
        begin
            if (stall_left == 0)
            begin
                stall_mode = rx_mode_t'($urandom_range(3));
                stall_left = $urandom_range(200, 20);
            end
            stall_left--;
            case (stall_mode)
                RX_FREE:     result_stall <= 1'b0;
                RX_LIGHT:    result_stall <= ($urandom_range(3) == 0);
                RX_HEAVY:    result_stall <= ($urandom_range(9) < 7);
                default:     result_stall <= ((stall_left % 16) < 5);
            endcase
        end
    end

    // present one beat, hold it until accepted, then maybe drop valid for a gap
    task automatic send_item(input logic op, input logic [VALUE_W-1:0] value,
                             input logic [SLOT_W-1:0] index);
        in_item_t beat;
        int       gap;
        beat.operation  = op;
        beat.item_value = value;
        beat.slot_index = index;
        item_valid <= 1'b1;
        item       <= beat;
        @(posedge clk);
        while (item_stall)
        begin
            @(posedge clk);
        end
        // add takes the lowest clear bit; a full pool stays full
        if (op == OP_ADD)
        begin
            occupied = occupied | (occupied + 1'b1);
        end
        else
        begin
            occupied[index] = 1'b0;
        end
        items_sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(40, 1);
            gap        = ($urandom_range(3) == 0) ? 0 : $urandom_range(10, 1);
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // mostly a live slot, sometimes any slot at all
    function automatic logic [SLOT_W-1:0] pick_drop_slot();
        int start;
        start = $urandom_range(SLOTS - 1);
        if (occupied != '0 && $urandom_range(99) < 85)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                if (occupied[(start + i) % SLOTS])
                begin
                    return SLOT_W'((start + i) % SLOTS);
                end
            end
        end
        return SLOT_W'(start);
    endfunction

    initial
    begin
        traffic_t mix;
        int       stretch;
        int       add_pct;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // drops on an empty pool, lowest and highest index
        send_item(OP_DROP, '0, '0);
        send_item(OP_DROP, {VALUE_W{1'b1}}, {SLOT_W{1'b1}});
        // build a four-slot list with extreme and alternating values
        send_item(OP_ADD, '0, '0);
        send_item(OP_ADD, {VALUE_W{1'b1}}, {SLOT_W{1'b1}});
        send_item(OP_ADD, 32'hA5A5_A5A5, 6'h2A);
        send_item(OP_ADD, 32'h5A5A_5A5A, 6'h15);
        // unlink from the middle, the head and the tail
        send_item(OP_DROP, 32'h0000_0001, 6'd1);
        send_item(OP_DROP, '0, 6'd0);
        send_item(OP_DROP, '0, 6'd3);
        // second drop of a slot already freed
        send_item(OP_DROP, '0, 6'd3);
        // last live slot goes, list empty again
        send_item(OP_DROP, '0, 6'd2);
        // fresh head and tail on an empty list
        send_item(OP_ADD, 32'h8000_0000, '0);
        send_item(OP_ADD, 32'h0000_0001, '0);
        send_item(OP_ADD, 32'h1234_5678, '0);
        // a hole in the middle is refilled but linked at the tail
        send_item(OP_DROP, '0, 6'd1);
        send_item(OP_ADD, 32'hDEAD_BEEF, '0);
        // free high slot while the list is not empty
        send_item(OP_DROP, '0, {SLOT_W{1'b1}});

        // random traffic in stretches; fill stretches run into the full pool,
        // drain stretches walk the list back down through all its positions
        while (items_sent < TOTAL_ITEMS)
        begin
            mix     = traffic_t'($urandom_range(3));
            stretch = $urandom_range(150, 30);
            case (mix)
                MIX_FILL:  add_pct = 90;
                MIX_DRAIN: add_pct = 10;
                default:   add_pct = 50;
            endcase
            repeat (stretch)
            begin
                if ($urandom_range(99) < add_pct)
                begin
                    send_item(OP_ADD, $urandom(), SLOT_W'($urandom_range(SLOTS - 1)));
                end
                else if (mix == MIX_NOISE)
                begin
                    send_item(OP_DROP, $urandom(), SLOT_W'($urandom_range(SLOTS - 1)));
                end
                else
                begin
                    send_item(OP_DROP, $urandom(), pick_drop_slot());
                end
            end
        end
        item_valid <= 1'b0;

        // let the checker log the last beat, then drain
        @(posedge clk);
        wait (outstanding == 0);
        repeat (10) @(posedge clk);

        if (failures == 0 && outstanding == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ pooled_doubly_linked_list_unit.f @@
rtl/pdll_pkg.sv
rtl/pdll_ram.sv
rtl/pdll_ctrl.sv
rtl/pdll_datapath.sv
rtl/pooled_doubly_linked_list_unit.sv
rtl/pdll_checker.sv
sim/pdll_list_checker.sv
sim/tb_pooled_doubly_linked_list_unit.sv
